// ===== design/bmfs_pkg.sv =====
// bmfs_pkg: shared types and constants of the biphase-mark frame sender
// no dependencies; imported by every module of the block

package bmfs_pkg;

  // widths of the item fields and configuration registers
  localparam int unsigned PAT_W    = 32;
  localparam int unsigned BIT_TK_W = 16;
  localparam int unsigned GAP_W    = 20;
  localparam int unsigned REP_W    = 8;
  localparam int unsigned SEG_W    = 20;
  localparam int unsigned CFG_IX_W = 2;
  localparam int unsigned CFG_D_W  = 20;

  // queue between front and back
  localparam int unsigned Q_DEPTH  = 2;
  localparam int unsigned Q_PTR_W  = 1;
  localparam int unsigned Q_CNT_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IX_W-1:0] CFG_BIT_TICKS    = 2'd0;
  localparam logic [CFG_IX_W-1:0] CFG_GAP_TICKS    = 2'd1;
  localparam logic [CFG_IX_W-1:0] CFG_REPEAT_COUNT = 2'd2;

  // configuration reset values
  localparam logic [BIT_TK_W-1:0] BIT_TICKS_RST    = 16'd4000;
  localparam logic [GAP_W-1:0]    GAP_TICKS_RST    = 20'd100000;
  localparam logic [REP_W-1:0]    REPEAT_COUNT_RST = 8'd10;

  // request codes
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } cmd_op_t;

  // one classified item
  typedef struct packed {
    cmd_op_t          op;
    logic [PAT_W-1:0] pattern;
  } cmd_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [BIT_TK_W-1:0] bit_ticks;
    logic [GAP_W-1:0]    gap_ticks;
    logic [REP_W-1:0]    repeat_count;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic carrier_on;
    logic busy_res;
    logic load_rejected;
  } res_t;

  // queue status towards the front and back
  typedef struct packed {
    logic not_full;
    logic not_empty;
  } q_stat_t;

endpackage

// ===== design/bmfs_front.sv =====
// bmfs_front: intake stage, registers and classifies each input item
// depends on bmfs_pkg; feeds bmfs_queue

module bmfs_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_req_type,
  input  logic [bmfs_pkg::PAT_W-1:0] in_pattern,
  input  logic                      q_not_full,
  output logic                      push,
  output bmfs_pkg::cmd_t            push_item
);
  import bmfs_pkg::*;

  logic fr_valid_r;
  logic fr_valid_nxt;
  cmd_t fr_item_r;
  logic accept;

  // hand the held item on whenever the queue has room
  assign push      = fr_valid_r && q_not_full;
  assign in_stall  = fr_valid_r && !q_not_full;
  assign accept    = in_valid && !in_stall;
  assign push_item = fr_item_r;

  // holding stage occupancy
  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) begin
      fr_valid_nxt = 1'b1;
    end else if (push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  // classify the request as tick or load
  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item_r.op      <= in_req_type ? OP_LOAD : OP_TICK;
      fr_item_r.pattern <= in_pattern;
    end
  end

endmodule

// ===== design/bmfs_queue.sv =====
// bmfs_queue: two-entry queue of classified items between front and back
// depends on bmfs_pkg

module bmfs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bmfs_pkg::cmd_t     push_item,
  input  logic               pop,
  output bmfs_pkg::cmd_t     head_item,
  output bmfs_pkg::q_stat_t  stat
);
  import bmfs_pkg::*;

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign stat.not_full  = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign stat.not_empty = (cnt_r != '0);
  assign head_item      = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/bmfs_back.sv =====
// bmfs_back: frame sequencer, runs one item per cycle unless stalled, holds the result register
// depends on bmfs_pkg; takes items from bmfs_queue

module bmfs_back #(
  parameter int unsigned PATTERN_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_not_empty,
  input  bmfs_pkg::cmd_t head_item,
  output logic           pop,
  input  bmfs_pkg::cfg_t cfg,
  output logic           out_valid,
  input  logic           out_stall,
  output bmfs_pkg::res_t out_res
);
  import bmfs_pkg::*;

  localparam int unsigned POS_W = $clog2(PATTERN_BITS);
  localparam int unsigned IDX_W = $clog2(PAT_W);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_BITS,
    PH_END_LONG,
    PH_END_SHORT,
    PH_GAP
  } phase_t;

  phase_t             phase_r,   phase_nxt;
  logic               line_r,    line_nxt;
  logic [SEG_W-1:0]   seg_r,     seg_nxt;
  logic [POS_W-1:0]   pos_r,     pos_nxt;
  logic               mid_r,     mid_nxt;
  logic [REP_W-1:0]   rep_r,     rep_nxt;
  logic [PAT_W-1:0]   pat_r,     pat_nxt;
  logic               out_valid_r;
  res_t               res_r,     res_nxt;

  logic [BIT_TK_W-1:0] unit;
  logic [SEG_W-1:0]    unit1, unit2, unit4, unit8;
  logic [REP_W-1:0]    want;
  logic [SEG_W-1:0]    seg_dec;
  logic                last_bit;
  logic                dbit_cur, dbit_next;
  logic [REP_W-1:0]    rep_inc;

  // segment lengths from the half-bit unit
  assign unit  = (cfg.bit_ticks == '0) ? BIT_TK_W'(1) : cfg.bit_ticks;
  assign unit1 = SEG_W'(unit);
  assign unit2 = unit1 << 1;
  assign unit4 = unit1 << 2;
  assign unit8 = unit1 << 3;
  assign want  = (cfg.repeat_count == '0) ? REP_W'(1) : cfg.repeat_count;

  // data bit at the current and the following position, zero past the pattern
  assign dbit_cur  = (32'(pos_r) >= 32'(PAT_W)) ? 1'b0 : pat_r[IDX_W'(pos_r)];
  assign dbit_next = ((32'(pos_r) + 32'd1) >= 32'(PAT_W)) ? 1'b0
                   : pat_r[IDX_W'(32'(pos_r) + 32'd1)];
  assign last_bit  = (32'(pos_r) + 32'd1) >= 32'(PATTERN_BITS);
  assign seg_dec   = (seg_r != '0) ? (seg_r - 1'b1) : seg_r;
  assign rep_inc   = rep_r + 1'b1;

  // take the head item when the result register is free or draining
  assign pop       = q_not_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // one step of the sequencer
  always_comb begin
    phase_nxt = phase_r;
    line_nxt  = line_r;
    seg_nxt   = seg_r;
    pos_nxt   = pos_r;
    mid_nxt   = mid_r;
    rep_nxt   = rep_r;
    pat_nxt   = pat_r;
    res_nxt.carrier_on    = 1'b0;
    res_nxt.load_rejected = 1'b0;

    if (head_item.op == OP_LOAD) begin
      if (phase_r != PH_IDLE) begin
        res_nxt.load_rejected = 1'b1;
        res_nxt.carrier_on    = line_r;
      end else begin
        pat_nxt   = head_item.pattern;
        rep_nxt   = '0;
        phase_nxt = PH_START;
        line_nxt  = 1'b1;
        seg_nxt   = unit8;
        pos_nxt   = '0;
        mid_nxt   = 1'b0;
        res_nxt.carrier_on = 1'b1;
      end
    end else if (phase_r != PH_IDLE) begin
      res_nxt.carrier_on = line_r;
      seg_nxt = seg_dec;
      if (seg_dec == '0) begin
        unique case (phase_r)
          PH_START: begin
            pos_nxt   = '0;
            phase_nxt = PH_BITS;
            line_nxt  = ~line_r;
            mid_nxt   = 1'b0;
            seg_nxt   = dbit_cur ? unit1 : unit2;
          end
          PH_BITS: begin
            if (dbit_cur && !mid_r) begin
              // second toggle of a one
              mid_nxt  = 1'b1;
              line_nxt = ~line_r;
              seg_nxt  = unit1;
            end else if (last_bit) begin
              pos_nxt   = '0;
              phase_nxt = PH_END_LONG;
              line_nxt  = ~line_r;
              seg_nxt   = unit4;
            end else begin
              pos_nxt   = pos_r + 1'b1;
              line_nxt  = ~line_r;
              mid_nxt   = 1'b0;
              seg_nxt   = dbit_next ? unit1 : unit2;
            end
          end
          PH_END_LONG: begin
            phase_nxt = PH_END_SHORT;
            line_nxt  = ~line_r;
            seg_nxt   = unit1;
          end
          PH_END_SHORT: begin
            line_nxt = 1'b0;
            rep_nxt  = rep_inc;
            if (cfg.gap_ticks != '0) begin
              phase_nxt = PH_GAP;
              seg_nxt   = SEG_W'(cfg.gap_ticks);
            end else if (rep_inc < want) begin
              phase_nxt = PH_START;
              line_nxt  = 1'b1;
              seg_nxt   = unit8;
              pos_nxt   = '0;
              mid_nxt   = 1'b0;
            end else begin
              phase_nxt = PH_IDLE;
              seg_nxt   = '0;
            end
          end
          PH_GAP: begin
            if (rep_r < want) begin
              phase_nxt = PH_START;
              line_nxt  = 1'b1;
              seg_nxt   = unit8;
              pos_nxt   = '0;
              mid_nxt   = 1'b0;
            end else begin
              phase_nxt = PH_IDLE;
              line_nxt  = 1'b0;
              seg_nxt   = '0;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            line_nxt  = 1'b0;
            seg_nxt   = '0;
          end
        endcase
      end
    end
    res_nxt.busy_res = (phase_nxt != PH_IDLE);
  end

  // sequencer state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      line_r      <= 1'b0;
      seg_r       <= '0;
      pos_r       <= '0;
      mid_r       <= 1'b0;
      rep_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        line_r  <= line_nxt;
        seg_r   <= seg_nxt;
        pos_r   <= pos_nxt;
        mid_r   <= mid_nxt;
        rep_r   <= rep_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pattern and result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      pat_r <= pat_nxt;
      res_r <= res_nxt;
    end
  end

endmodule

// ===== design/biphase_mark_ir_frame_sender_top.sv =====
// Biphase-mark IR frame sender takes one tick or load item per cycle while nothing stalls
// and gives one result item for each, via the intake register, queue and result register;
// the rate is set by the sequencer, which advances its segment counter by one tick per
// item. A load while idle starts repeat_count frames, zero counting as one (start mark,
// data bits low first in biphase-mark code, end marker, gap if gap_ticks is nonzero);
// a load while busy is refused and flagged. Write configuration only while no item is in
// flight; a value written during a frame takes effect from the next segment on.
// depends on bmfs_pkg, bmfs_front, bmfs_queue, bmfs_back

module biphase_mark_ir_frame_sender_top #(
  parameter int unsigned PATTERN_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic [bmfs_pkg::PAT_W-1:0]   in_pattern,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_carrier_on,
  output logic                         out_busy_res,
  output logic                         out_load_rejected,
  input  logic                         cfg_we,
  input  logic [bmfs_pkg::CFG_IX_W-1:0] cfg_index,
  input  logic [bmfs_pkg::CFG_D_W-1:0]  cfg_wdata
);
  import bmfs_pkg::*;

  cfg_t    cfg_r;
  logic    push;
  cmd_t    push_item;
  logic    pop;
  cmd_t    head_item;
  q_stat_t q_stat;
  res_t    res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_ticks    <= BIT_TICKS_RST;
      cfg_r.gap_ticks    <= GAP_TICKS_RST;
      cfg_r.repeat_count <= REPEAT_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BIT_TICKS:    cfg_r.bit_ticks    <= cfg_wdata[BIT_TK_W-1:0];
        CFG_GAP_TICKS:    cfg_r.gap_ticks    <= cfg_wdata[GAP_W-1:0];
        CFG_REPEAT_COUNT: cfg_r.repeat_count <= cfg_wdata[REP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bmfs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_pattern  (in_pattern),
    .q_not_full  (q_stat.not_full),
    .push        (push),
    .push_item   (push_item)
  );

  bmfs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  bmfs_back #(
    .PATTERN_BITS (PATTERN_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_stat.not_empty),
    .head_item   (head_item),
    .pop         (pop),
    .cfg         (cfg_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (res)
  );

  assign out_carrier_on    = res.carrier_on;
  assign out_busy_res      = res.busy_res;
  assign out_load_rejected = res.load_rejected;

  // a refused load only happens while frames are still running
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_load_rejected |-> out_busy_res)
    else $error("refused load reported while idle");

  // nothing comes out in the first cycle out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

  // the back end only takes from a queue that holds an item
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.not_empty)
    else $error("queue read while empty");

  // the intake stage only stalls while the queue is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !q_stat.not_full)
    else $error("input stalled with room in the queue");

endmodule

// ===== sim/biphase_mark_ir_frame_sender_top_tb.sv =====
// testbench for the biphase-mark ir frame sender: directed and random tick and load items
// depends on bmfs_pkg and biphase_mark_ir_frame_sender_top; self-checking against its own predictor
`timescale 1ns / 1ps

module biphase_mark_ir_frame_sender_top_tb;
  import bmfs_pkg::*;

  localparam int unsigned FRAME_BITS  = 32;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_AT     = 1000;
  localparam int unsigned HOLD_LEN    = 300;
  localparam int unsigned SETTLE_LAT  = 4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_BITS, ST_END_LONG, ST_END_SHORT, ST_GAP
  } send_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_req_type = 1'b0;
  logic [PAT_W-1:0] in_pattern = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_carrier_on;
  logic out_busy_res;
  logic out_load_rejected;
  logic cfg_we = 1'b0;
  logic [CFG_IX_W-1:0] cfg_index = CFG_BIT_TICKS;
  logic [CFG_D_W-1:0] cfg_wdata = '0;

  // items waiting to be offered and result items still owed by the block
  cmd_t req_backlog[$];
  res_t levels_due[$];

  // predictor copy of the configuration
  logic [BIT_TK_W-1:0] cfg_bit = BIT_TICKS_RST;
  logic [GAP_W-1:0]    cfg_gap = GAP_TICKS_RST;
  logic [REP_W-1:0]    cfg_rep = REPEAT_COUNT_RST;

  // predictor copy of the sender state
  send_phase_t      tx_phase = ST_IDLE;
  logic             lvl = 1'b0;
  logic [SEG_W-1:0] seg_left = '0;
  int unsigned      bit_pos = 0;
  logic             mid_done = 1'b0;
  logic [REP_W-1:0] frames_done = '0;
  logic [PAT_W-1:0] shift_reg = '0;

  int unsigned cycle_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        calm;

  assign calm = (cycle_cnt >= 2000) && (cycle_cnt < 5000);

  biphase_mark_ir_frame_sender_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_pattern        (in_pattern),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_carrier_on    (out_carrier_on),
    .out_busy_res      (out_busy_res),
    .out_load_rejected (out_load_rejected),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #6 clk = ~clk;

  // half bit time, zero counts as one
  function automatic logic [SEG_W-1:0] unit_len();
    return (cfg_bit == '0) ? SEG_W'(1) : SEG_W'(cfg_bit);
  endfunction

  function automatic void start_frame();
    tx_phase = ST_START;
    lvl      = 1'b1;
    seg_left = SEG_W'(8 * unit_len());
    bit_pos  = 0;
    mid_done = 1'b0;
  endfunction

  // every bit opens with a toggle; a 0 holds for a full bit time
  function automatic void start_bit();
    tx_phase = ST_BITS;
    lvl      = ~lvl;
    mid_done = 1'b0;
    seg_left = shift_reg[bit_pos] ? unit_len() : SEG_W'(2 * unit_len());
  endfunction

  function automatic void next_frame_or_idle();
    logic [REP_W-1:0] wanted;
    wanted = (cfg_rep == '0) ? REP_W'(1) : cfg_rep;
    if (frames_done < wanted) begin
      start_frame();
    end else begin
      tx_phase = ST_IDLE;
      lvl      = 1'b0;
      seg_left = '0;
    end
  endfunction

  // one accepted item moves the sender on by one tick, starts it, or is refused as a load while busy
  function automatic res_t advance_sender(input cmd_t c);
    res_t r;
    r = '0;
    if (c.op == OP_LOAD) begin
      if (tx_phase != ST_IDLE) begin
        r.load_rejected = 1'b1;
      end else begin
        shift_reg   = c.pattern;
        frames_done = '0;
        start_frame();
      end
      r.carrier_on = lvl;
    end else if (tx_phase != ST_IDLE) begin
      r.carrier_on = lvl;
      if (seg_left != '0) seg_left = seg_left - 1'b1;
      if (seg_left == '0) begin
        case (tx_phase)
          ST_START: begin
            bit_pos = 0;
            start_bit();
          end
          ST_BITS: begin
            if (shift_reg[bit_pos] && !mid_done) begin
              mid_done = 1'b1;
              lvl      = ~lvl;
              seg_left = unit_len();
            end else begin
              bit_pos++;
              if (bit_pos >= FRAME_BITS) begin
                tx_phase = ST_END_LONG;
                lvl      = ~lvl;
                seg_left = SEG_W'(4 * unit_len());
              end else begin
                start_bit();
              end
            end
          end
          ST_END_LONG: begin
            tx_phase = ST_END_SHORT;
            lvl      = ~lvl;
            seg_left = unit_len();
          end
          ST_END_SHORT: begin
            lvl         = 1'b0;
            frames_done = frames_done + 1'b1;
            if (cfg_gap != '0) begin
              tx_phase = ST_GAP;
              seg_left = cfg_gap;
            end else begin
              next_frame_or_idle();
            end
          end
          ST_GAP: next_frame_or_idle();
          default: begin
            tx_phase = ST_IDLE;
            lvl      = 1'b0;
            seg_left = '0;
          end
        endcase
      end
    end
    r.busy_res = (tx_phase != ST_IDLE);
    return r;
  endfunction

  function automatic cmd_t mk_item(input cmd_op_t op, input logic [PAT_W-1:0] pat);
    cmd_t c;
    c.op      = op;
    c.pattern = pat;
    return c;
  endfunction

  // driver: offers backlog items, predicts each one as it is taken
  always @(posedge clk) begin : drv
    cmd_t cur;
    logic go;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      go = in_valid;
      if (in_valid && !in_stall) begin
        levels_due.push_back(advance_sender(mk_item(cmd_op_t'(in_req_type), in_pattern)));
        go = 1'b0;
      end
      if (!go && req_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 27)) begin
        cur = req_backlog.pop_front();
        in_req_type <= cur.op;
        in_pattern  <= cur.pattern;
        go = 1'b1;
      end
      in_valid <= go;
    end
  end

  // monitor: checks result items in order and drives the receiver stall
  always @(posedge clk) begin : mon
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.carrier_on    = out_carrier_on;
        got.busy_res      = out_busy_res;
        got.load_rejected = out_load_rejected;
        results_seen++;
        if (levels_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result item %0d arrived with nothing expected", results_seen);
        end else begin
          want = levels_due.pop_front();
          if (got.carrier_on !== want.carrier_on || got.busy_res !== want.busy_res ||
              got.load_rejected !== want.load_rejected) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result item %0d: expected carrier %b busy %b rejected %b, got %b %b %b",
                       results_seen, want.carrier_on, want.busy_res, want.load_rejected,
                       got.carrier_on, got.busy_res, got.load_rejected);
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 27);
      end
    end
  end

  // run-time guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt + 1 >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || levels_due.size() != 0);
  endtask

  // tick on until every loaded frame has gone out
  task automatic settle();
    wait_drained();
    while (tx_phase != ST_IDLE) begin
      repeat (128) req_backlog.push_back(mk_item(OP_TICK, $urandom()));
      wait_drained();
    end
    repeat (SETTLE_LAT) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IX_W-1:0] idx, input logic [CFG_D_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // all three registers, with nothing in flight
  task automatic write_all(input int unsigned bt, input int unsigned gp, input int unsigned rp);
    write_reg(CFG_BIT_TICKS, CFG_D_W'(bt));
    cfg_bit = BIT_TK_W'(bt);
    write_reg(CFG_GAP_TICKS, CFG_D_W'(gp));
    cfg_gap = GAP_W'(gp);
    write_reg(CFG_REPEAT_COUNT, CFG_D_W'(rp));
    cfg_rep = REP_W'(rp);
  endtask

  task automatic configure(input int unsigned bt, input int unsigned gp, input int unsigned rp);
    settle();
    write_all(bt, gp, rp);
  endtask

  initial begin : stim
    logic [PAT_W-1:0] pat;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // ticks while idle under the reset configuration
    repeat (2) req_backlog.push_back(mk_item(OP_TICK, $urandom()));

    // largest register values, idle only
    configure(65535, 1048575, 255);
    repeat (2) req_backlog.push_back(mk_item(OP_TICK, $urandom()));

    // zero bit time, zero gap and zero repeats; refused load mid-frame
    configure(0, 0, 0);
    req_backlog.push_back(mk_item(OP_LOAD, 32'hFFFF_FFFF));
    repeat (3) req_backlog.push_back(mk_item(OP_TICK, $urandom()));
    req_backlog.push_back(mk_item(OP_LOAD, 32'h0000_0000));
    req_backlog.push_back(mk_item(OP_TICK, $urandom()));
    settle();
    req_backlog.push_back(mk_item(OP_LOAD, 32'h0000_0000));
    req_backlog.push_back(mk_item(OP_TICK, $urandom()));

    // several frames back to back with no gap
    configure(1, 0, 3);
    req_backlog.push_back(mk_item(OP_LOAD, 32'hA5A5_5A5A));
    req_backlog.push_back(mk_item(OP_TICK, $urandom()));
    req_backlog.push_back(mk_item(OP_LOAD, 32'h1234_5678));

    // short gap between two frames
    configure(2, 1, 2);
    req_backlog.push_back(mk_item(OP_LOAD, 32'h8000_0001));
    req_backlog.push_back(mk_item(OP_TICK, $urandom()));

    // gap count past eight bits, left running into the random phases
    configure(3, 300, 1);
    req_backlog.push_back(mk_item(OP_LOAD, $urandom()));
    req_backlog.push_back(mk_item(OP_TICK, $urandom()));

    // random phases with short frames; registers rewritten once drained, possibly mid-frame
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      write_all($urandom_range(0, 3),
                ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30),
                $urandom_range(0, 4));
      for (int i = 0; i < 130; i++) begin
        if ($urandom_range(0, 99) < 6) begin
          case ($urandom_range(0, 7))
            0: pat = 32'hFFFF_FFFF;
            1: pat = 32'h0000_0000;
            2: pat = 32'h5555_5555;
            default: pat = $urandom();
          endcase
          req_backlog.push_back(mk_item(OP_LOAD, pat));
        end else begin
          req_backlog.push_back(mk_item(OP_TICK, $urandom()));
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && levels_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== biphase_mark_ir_frame_sender_top.f =====
design/bmfs_pkg.sv
design/bmfs_front.sv
design/bmfs_queue.sv
design/bmfs_back.sv
design/biphase_mark_ir_frame_sender_top.sv
sim/biphase_mark_ir_frame_sender_top_tb.sv
